// ----- rtl/pcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and codes of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    localparam int PageShift = 12;
    localparam int PageNumW  = 20;
    localparam int LimitW    = 21;
    localparam int AddrW     = 32;
    localparam int CpuFieldW = 3;
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = 21;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_FIRST_PAGE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_LIMIT_PAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_POP
    } state_t;

endpackage

// ----- rtl/pcpa_req_if.sv -----
// ----------------------------------------------------------------------------
// pcpa_req_if
// Request channel: one beat carries an allocate or a free.
// ----------------------------------------------------------------------------
interface pcpa_req_if;

    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  cpu;
    logic [31:0] free_addr;

    modport source (output valid, output func, output cpu, output free_addr, input ready);
    modport sink   (input valid, input func, input cpu, input free_addr, output ready);

endinterface

// ----- rtl/pcpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pcpa_rsp_if
// Response channel: one beat carries the page address and a status.
// ----------------------------------------------------------------------------
interface pcpa_rsp_if;

    logic        valid;
    logic        ready;
    logic [31:0] page_addr;
    logic [1:0]  status;

    modport source (output valid, output page_addr, output status, input ready);
    modport sink   (input valid, input page_addr, input status, output ready);

endinterface

// ----- rtl/pcpa_ram.sv -----
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pcpa_lists.sv -----
// ----------------------------------------------------------------------------
// pcpa_lists
// Head registers and non-empty flags of the per-CPU lists, with the pick of
// the list to pop from (own list first, else the lowest non-empty one).
// ----------------------------------------------------------------------------
module pcpa_lists #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [(NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1)-1:0] query_idx,
    input  logic                                       steal,
    output logic [(NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1)-1:0] pick_idx,
    output logic                                       pick_nonempty,
    output logic [$clog2(NUM_PAGES)-1:0]               pick_head,
    input  logic                                       upd_en,
    input  logic [(NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1)-1:0] upd_idx,
    input  logic [$clog2(NUM_PAGES)-1:0]               upd_head,
    input  logic                                       upd_nonempty
);

    localparam int CpuW  = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
    localparam int SlotW = $clog2(NUM_PAGES);

    logic [SlotW-1:0]    head_reg [NUM_CPUS];
    logic [NUM_CPUS-1:0] nonempty_reg;
    logic [CpuW-1:0]     lowest;

    always_comb
    begin
        lowest = query_idx;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                lowest = CpuW'(i);
            end
        end
    end

    always_comb
    begin
        if (steal && !nonempty_reg[query_idx])
        begin
            pick_idx = lowest;
        end
        else
        begin
            pick_idx = query_idx;
        end
    end

    assign pick_nonempty = nonempty_reg[pick_idx];
    assign pick_head     = head_reg[pick_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            head_reg[upd_idx]     <= upd_head;
            nonempty_reg[upd_idx] <= upd_nonempty;
        end
    end

endmodule

// ----- rtl/per_cpu_page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Page allocator with one LIFO free list per CPU and stealing on empty.
//
// A request beat on req is either a free, which pushes the page at free_addr
// onto the list of the named CPU, or an allocate, which pops a page from the
// requesting CPU's list, else from the lowest-numbered non-empty list. Every
// request gives exactly one response beat on rsp with page_addr and status
// (ok, out of memory, or bad address on a refused free).
// Each request passes through S_IDLE, where the accept reads the list head
// and issues the next-link memory read, then S_FREE or S_POP, which writes
// the link or consumes the read data and loads the response register. A new
// request is taken once the previous response sits in that register, so a
// waiting response does not hold off the next request. When rsp stalls with
// a response still held, S_FREE or S_POP waits until the register frees.
// Reset empties every list and clears first_page and limit_page; link memory
// needs no clearing pass. The user, not the block, must write through the
// configuration port first_page (index 0) and limit_page (index 1) while idle.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator
    import pcpa_pkg::*;
#(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    pcpa_req_if.sink            req,
    pcpa_rsp_if.source          rsp,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    localparam int CpuW  = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
    localparam int SlotW = $clog2(NUM_PAGES);
    localparam int LinkW = SlotW + 1;

    state_t              state_reg, state_next;
    logic [PageNumW-1:0] first_page_reg;
    logic [LimitW-1:0]   limit_page_reg;
    logic [CpuW-1:0]     cpu_reg;
    logic [AddrW-1:0]    addr_reg;
    logic [CpuW-1:0]     pick_reg;
    logic                found_reg;
    logic                rsp_valid_reg;
    logic [AddrW-1:0]    page_addr_reg, page_addr_next;
    status_t             status_reg, status_next;

    logic [CpuFieldW-1:0] cpu_red;
    logic [CpuW-1:0]      cpu_idx;
    logic                 accept;
    logic                 out_space;
    logic                 load_rsp;

    logic [CpuW-1:0]  query_idx;
    logic             steal;
    logic [CpuW-1:0]  pick_idx;
    logic             pick_nonempty;
    logic [SlotW-1:0] pick_head;
    logic             upd_en;
    logic [CpuW-1:0]  upd_idx;
    logic [SlotW-1:0] upd_head;
    logic             upd_nonempty;

    logic             ram_we;
    logic [LinkW-1:0] ram_wdata;
    logic             ram_re;
    logic [LinkW-1:0] ram_rdata;

    logic [PageNumW-1:0] free_page;
    logic [PageNumW-1:0] free_slot;
    logic                free_bad;
    logic [PageNumW-1:0] pop_page;

    always_comb
    begin
        cpu_red = req.cpu;
        for (int i = 0; i < 8; i++)
        begin
            if (32'(cpu_red) >= NUM_CPUS)
            begin
                cpu_red = cpu_red - CpuFieldW'(NUM_CPUS);
            end
        end
    end

    assign cpu_idx   = CpuW'(cpu_red);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_space = !rsp_valid_reg || rsp.ready;

    assign free_page = addr_reg[AddrW-1:PageShift];
    assign free_slot = free_page - first_page_reg;
    assign free_bad  = (addr_reg[PageShift-1:0] != '0)
                    || (free_page < first_page_reg)
                    || ({1'b0, free_page} >= limit_page_reg)
                    || ({1'b0, free_slot} >= LimitW'(NUM_PAGES));
    assign pop_page  = first_page_reg + PageNumW'(pick_head);

    pcpa_lists #(
        .NUM_CPUS  (NUM_CPUS),
        .NUM_PAGES (NUM_PAGES)
    ) u_lists (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_idx     (query_idx),
        .steal         (steal),
        .pick_idx      (pick_idx),
        .pick_nonempty (pick_nonempty),
        .pick_head     (pick_head),
        .upd_en        (upd_en),
        .upd_idx       (upd_idx),
        .upd_head      (upd_head),
        .upd_nonempty  (upd_nonempty)
    );

    pcpa_ram #(
        .WIDTH (LinkW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot[SlotW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pick_head),
        .rdata (ram_rdata)
    );

    assign ram_wdata = pick_nonempty ? (LinkW'(pick_head) + LinkW'(1)) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.func == FUNC_FREE) ? S_FREE : S_POP;
                end
            end
            S_FREE, S_POP:
            begin
                if (out_space)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        query_idx      = cpu_reg;
        steal          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        upd_en         = 1'b0;
        upd_idx        = cpu_reg;
        upd_head       = pick_head;
        upd_nonempty   = 1'b1;
        load_rsp       = 1'b0;
        page_addr_next = '0;
        status_next    = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                query_idx = cpu_idx;
                steal     = 1'b1;
                ram_re    = accept && (req.func == FUNC_ALLOC) && pick_nonempty;
            end
            S_FREE:
            begin
                load_rsp = out_space;
                if (free_bad)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    ram_we   = out_space;
                    upd_en   = out_space;
                    upd_head = free_slot[SlotW-1:0];
                end
            end
            S_POP:
            begin
                query_idx = pick_reg;
                load_rsp  = out_space;
                if (!found_reg)
                begin
                    status_next = ST_OOM;
                end
                else
                begin
                    page_addr_next = {pop_page, {PageShift{1'b0}}};
                    upd_en         = out_space;
                    upd_idx        = pick_reg;
                    upd_nonempty   = (ram_rdata != '0);
                    upd_head       = (ram_rdata != '0)
                                   ? SlotW'(ram_rdata - LinkW'(1)) : '0;
                end
            end
            default:
            begin
                query_idx = cpu_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            first_page_reg <= '0;
            limit_page_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIRST_PAGE: first_page_reg <= cfg_wdata[PageNumW-1:0];
                    CFG_LIMIT_PAGE: limit_page_reg <= cfg_wdata[LimitW-1:0];
                    default:        first_page_reg <= first_page_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cpu_reg   <= cpu_idx;
            addr_reg  <= req.free_addr;
            pick_reg  <= pick_idx;
            found_reg <= pick_nonempty;
        end
        if (load_rsp)
        begin
            page_addr_reg <= page_addr_next;
            status_reg    <= status_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.page_addr = page_addr_reg;
    assign rsp.status    = status_reg;

endmodule

// ----- dv/tb_per_cpu_page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// Self-checking testbench for the per-CPU page free-list allocator.
//
// A queue of request beats feeds a clocked driver, and a clocked monitor
// compares every response beat with the oldest predicted grant. The
// prediction keeps its own per-CPU LIFO lists, link memory and range
// registers. A directed part covers range edges, refused frees, stealing,
// out of memory, address wrap with a moved first page and a double free.
// Random phases under several page ranges follow, with random idling on
// both sides after the first, and one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_per_cpu_page_free_list_allocator;
    import pcpa_pkg::*;

    localparam int NumCpus   = 8;
    localparam int NumPages  = 32768;
    localparam int CycleCap  = 60000;
    localparam int HoldSpan  = 300;

    typedef struct packed {
        logic              func;
        logic [2:0]        cpu;
        logic [AddrW-1:0]  free_addr;
    } page_req_t;

    typedef struct packed {
        logic [AddrW-1:0]  page_addr;
        status_t           status;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    pcpa_req_if req_ch ();
    pcpa_rsp_if rsp_ch ();

    per_cpu_page_free_list_allocator #(
        .NUM_CPUS  (NumCpus),
        .NUM_PAGES (NumPages)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    page_req_t req_backlog[$];
    grant_t    expected_grants[$];

    bit [PageNumW-1:0] cur_first;
    bit [LimitW-1:0]   cur_limit;
    bit [14:0]         list_top [NumCpus];
    bit                list_live [NumCpus];
    bit [15:0]         link_mem [NumPages];

    bit   slot_taken [int];
    int   pages_held;
    bit   quiet;
    bit   hold_req;
    bit   hold_served;
    int   stall_left;
    int   err_cnt;
    int   cycle_cnt;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit page_ok(logic [AddrW-1:0] addr);
        int pg;
        pg = int'(addr[AddrW-1:PageShift]);
        return addr[PageShift-1:0] == '0 && pg >= int'(cur_first) && pg < int'(cur_limit)
            && pg - int'(cur_first) < NumPages;
    endfunction

    function automatic grant_t predict_grant(page_req_t r);
        grant_t      g;
        int          c;
        int          slot;
        int          pick;
        bit [14:0]   top;
        bit [15:0]   lnk;
        logic [31:0] page_num;
        g.page_addr = '0;
        g.status    = ST_OK;
        c           = int'(r.cpu) % NumCpus;
        pick        = -1;
        if (r.func == FUNC_FREE)
        begin
            if (!page_ok(r.free_addr))
            begin
                g.status = ST_BAD;
            end
            else
            begin
                slot = int'(r.free_addr[AddrW-1:PageShift]) - int'(cur_first);
                link_mem[slot] = list_live[c] ? {1'b0, list_top[c]} + 16'd1 : 16'd0;
                list_top[c]    = slot[14:0];
                list_live[c]   = 1'b1;
            end
        end
        else
        begin
            if (list_live[c])
            begin
                pick = c;
            end
            else
            begin
                for (int i = 0; i < NumCpus; i++)
                begin
                    if (pick < 0 && i != c && list_live[i])
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                g.status = ST_OOM;
            end
            else
            begin
                top = list_top[pick];
                lnk = link_mem[top];
                if (lnk == 16'd0)
                begin
                    list_live[pick] = 1'b0;
                    list_top[pick]  = '0;
                end
                else
                begin
                    list_top[pick] = 15'(lnk - 16'd1);
                end
                page_num    = 32'(cur_first) + 32'(top);
                g.page_addr = page_num << PageShift;
            end
        end
        return g;
    endfunction

    // Request driver: a beat stays offered until it is taken.
    always @(posedge clk)
    begin : drive_req
        page_req_t nxt;
        if (rst_n && (!req_ch.valid || req_ch.ready))
        begin
            if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 9))
            begin
                nxt = req_backlog.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.func      <= nxt.func;
                req_ch.cpu       <= nxt.cpu;
                req_ch.free_addr <= nxt.free_addr;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (hold_req && !hold_served)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= HoldSpan;
                hold_served  <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= quiet || $urandom_range(99) >= 9;
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        grant_t    want;
        page_req_t taken;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected response beat page_addr=%h status=%0d",
                         $time, rsp_ch.page_addr, rsp_ch.status);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp_ch.page_addr !== want.page_addr)
                begin
                    err_cnt++;
                    $display("%0t: page_addr expected %h actual %h",
                             $time, want.page_addr, rsp_ch.page_addr);
                end
                if (rsp_ch.status !== want.status)
                begin
                    err_cnt++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                end
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            taken.func      = req_ch.func;
            taken.cpu       = req_ch.cpu;
            taken.free_addr = req_ch.free_addr;
            expected_grants.push_back(predict_grant(taken));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleCap)
        begin
            $display("per_cpu_page_free_list_allocator: mismatch");
            $finish;
        end
    end

    task automatic push_req(logic func, int cpu, logic [AddrW-1:0] addr);
        page_req_t r;
        r.func      = func;
        r.cpu       = 3'(cpu);
        r.free_addr = addr;
        req_backlog.push_back(r);
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_ch.valid || expected_grants.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_range(int first_pg, int limit_pg);
        drain();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_PAGE;
        cfg_wdata <= CfgDataW'(first_pg);
        @(posedge clk);
        cfg_index <= CFG_LIMIT_PAGE;
        cfg_wdata <= CfgDataW'(limit_pg);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_first = PageNumW'(first_pg);
        cur_limit = LimitW'(limit_pg);
        slot_taken.delete();
        pages_held = 0;
    endtask

    task automatic random_items(int n);
        int          span;
        int          pick;
        int          s;
        logic [31:0] addr;
        span = int'(cur_limit) - int'(cur_first);
        if (span > NumPages)
            span = NumPages;
        if (span < 0)
            span = 0;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                push_req(FUNC_ALLOC, $urandom_range(NumCpus - 1), $urandom);
                if (pages_held > 0)
                    pages_held--;
            end
            else if (pick < 88 && slot_taken.num() < span)
            begin
                do
                    s = $urandom_range(span - 1);
                while (slot_taken.exists(s));
                slot_taken[s] = 1'b1;
                addr = (32'(cur_first) + 32'(s)) << PageShift;
                push_req(FUNC_FREE, $urandom_range(NumCpus - 1), addr);
                pages_held++;
            end
            else
            begin
                addr = $urandom;
                if ($urandom_range(1) == 0)
                    addr[PageShift-1:0] = '0;
                if (page_ok(addr))
                    addr[PageShift-1:0] = 12'h800;
                push_req(FUNC_FREE, $urandom_range(NumCpus - 1), addr);
            end
        end
    endtask

    task automatic empty_lists();
        for (int k = 0; k <= pages_held; k++)
            push_req(FUNC_ALLOC, $urandom_range(NumCpus - 1), $urandom);
        pages_held = 0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_FIRST_PAGE;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_ALLOC;
        req_ch.cpu       = '0;
        req_ch.free_addr = '0;
        rsp_ch.ready     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Both ranges are zero after reset, so nothing can be freed.
        push_req(FUNC_ALLOC, 0, 32'h0);
        push_req(FUNC_FREE, 3, 32'h0000_1000);

        set_range(20'h00100, 21'h00140);
        push_req(FUNC_FREE, 0, 32'h0010_0000);
        push_req(FUNC_FREE, 7, 32'h0013_F000);
        push_req(FUNC_FREE, 1, 32'h0014_0000);
        push_req(FUNC_FREE, 1, 32'h000F_F000);
        push_req(FUNC_FREE, 2, 32'h0012_0800);
        push_req(FUNC_FREE, 5, 32'hFFFF_FFFF);
        push_req(FUNC_FREE, 0, 32'h0012_1000);
        push_req(FUNC_ALLOC, 0, 32'hFFFF_FFFF);
        push_req(FUNC_ALLOC, 3, 32'h0);
        push_req(FUNC_ALLOC, 3, 32'h0);
        push_req(FUNC_ALLOC, 6, 32'h0);
        push_req(FUNC_FREE, 2, 32'h0010_5000);
        push_req(FUNC_FREE, 2, 32'h0010_6000);

        // Pages stay on the lists while the first page moves to the top,
        // so their addresses wrap past 32 bits.
        set_range(20'hFFFFF, 21'h100000);
        push_req(FUNC_ALLOC, 2, 32'h0);
        push_req(FUNC_ALLOC, 5, 32'h0);
        push_req(FUNC_FREE, 1, 32'hFFFF_F000);
        push_req(FUNC_ALLOC, 1, 32'h0);
        push_req(FUNC_ALLOC, 0, 32'h0);

        set_range(20'h80000, 21'h00010);
        push_req(FUNC_FREE, 4, 32'h8000_0000);
        push_req(FUNC_ALLOC, 4, 32'h0);

        quiet = 1'b1;
        set_range(20'h00010, 21'h00110);
        random_items(100);
        empty_lists();
        drain();
        quiet = 1'b0;

        set_range(20'hFFF00, 21'h100000);
        random_items(40);
        while (req_backlog.size() != 0)
            @(negedge clk);
        hold_req = 1'b1;
        random_items(60);
        empty_lists();

        set_range(20'h00000, 21'h100000);
        random_items(50);
        drain();
        random_items(50);
        empty_lists();

        set_range(20'h12345, 21'h1A345);
        random_items(100);
        empty_lists();

        // A page freed twice links to itself, so its list never runs dry.
        set_range(20'h00200, 21'h00210);
        push_req(FUNC_FREE, 4, 32'h0020_0000);
        push_req(FUNC_FREE, 4, 32'h0020_0000);
        push_req(FUNC_ALLOC, 4, 32'h0);
        push_req(FUNC_ALLOC, 4, 32'h0);
        push_req(FUNC_ALLOC, 4, 32'h0);

        drain();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("per_cpu_page_free_list_allocator: match");
        else
            $display("per_cpu_page_free_list_allocator: mismatch");
        $finish;
    end

endmodule
